@@ rtl/core/ovbp_pkg.sv @@
package ovbp_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam logic [1:0] SKIP_CHUNKS = 2'd3;
  localparam logic [31:0] WORD_BYTES = 32'd4;

  typedef enum logic [1:0] {
    ACT_DATA    = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_CLEAR   = 2'd3
  } ovbp_act_t;

  // one data word travelling down the cell row
  typedef struct packed {
    logic [31:0] pos;
    logic        apply;
    logic [7:0]  data;
    logic        patched;
    logic        mismatch;
    logic        last;
  } ovbp_item_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic        en;
    logic [31:0] offset;
    logic [31:0] expected;
    logic [31:0] replacement;
  } ovbp_wr_t;

  // big-endian: byte 0 is the most significant
  function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] n);
    logic [7:0] b;
    unique case (n)
      2'd0: b = word[31:24];
      2'd1: b = word[23:16];
      2'd2: b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/ovbp_cell.sv @@
module ovbp_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [CW-1:0]       count,
  input  ovbp_pkg::ovbp_wr_t  wr,
  input  logic                in_valid,
  input  ovbp_pkg::ovbp_item_t in_item,
  output logic                out_valid,
  output ovbp_pkg::ovbp_item_t out_item
);
  import ovbp_pkg::*;

  logic [31:0] offset_r;
  logic [31:0] expected_r;
  logic [31:0] replacement_r;
  logic        valid_r;
  ovbp_item_t  item_r;
  ovbp_item_t  item_nxt;
  logic [31:0] n;
  logic        covered;
  logic [7:0]  exp_b;

  always_ff @(posedge clk) begin
    if (wr.en && (count == CW'(IDX))) begin
      offset_r      <= wr.offset;
      expected_r    <= wr.expected;
      replacement_r <= wr.replacement;
    end
  end

  always_comb begin
    n        = in_item.pos - offset_r;
    covered  = in_item.apply && (CW'(IDX) < count) && (n < WORD_BYTES);
    exp_b    = word_byte(expected_r, n[1:0]);
    item_nxt = in_item;
    if (covered) begin
      if (in_item.data == exp_b) begin
        item_nxt.data    = word_byte(replacement_r, n[1:0]);
        item_nxt.patched = 1'b1;
      end else begin
        item_nxt.mismatch = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/core/offset_verified_byte_patcher_core.sv @@
// A data word passes through every cell of the row, each a register, before it is on out_.
// Throughput: one data word per cycle; the row of cells is a stalling shift chain.
// Append and clear words wait until no data word is in the chain and the chain can advance.
// Restart is accepted whenever the chain can advance. Other words produce no output.
// Reset (rst_n low, synchronous): table empty, position zero, skip count zero, chain empty.
module offset_verified_byte_patcher_core #(
  parameter int MAX_ENTRIES = ovbp_pkg::DEF_MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] data_byte, [39:8] entry_offset, [71:40] entry_expected, [103:72] entry_replacement
  input  logic [103:0] in_tdata,
  // [1:0] action
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] out_byte
  output logic [7:0]   out_tdata,
  // [0] was_patched, [1] saw_mismatch
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import ovbp_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] inflight_r, inflight_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [1:0]    skipped_r, skipped_nxt;

  ovbp_act_t  act;
  logic       adv;
  logic       in_fire;
  logic       out_fire;
  logic       data_fire;
  logic       apply;
  ovbp_wr_t   wr;
  ovbp_item_t head_item;

  logic       chain_valid [MAX_ENTRIES+1];
  ovbp_item_t chain_item  [MAX_ENTRIES+1];

  assign act       = ovbp_act_t'(in_tuser);
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && !(((act == ACT_APPEND) || (act == ACT_CLEAR)) &&
                              (inflight_r != '0));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign data_fire = in_fire && (act == ACT_DATA);
  assign apply     = (count_r != '0) && (skipped_r == SKIP_CHUNKS);

  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    skipped_nxt = skipped_r;
    wr.en          = 1'b0;
    wr.offset      = in_tdata[39:8];
    wr.expected    = in_tdata[71:40];
    wr.replacement = in_tdata[103:72];
    if (in_fire) begin
      unique case (act)
        ACT_DATA: begin
          if (count_r != '0) begin
            if (skipped_r != SKIP_CHUNKS) begin
              if (in_tlast) skipped_nxt = skipped_r + 2'd1;
            end else begin
              pos_nxt = pos_r + 32'd1;
            end
          end
        end
        ACT_APPEND: begin
          if (count_r < CW'(MAX_ENTRIES)) begin
            wr.en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_RESTART: begin
          pos_nxt     = '0;
          skipped_nxt = SKIP_CHUNKS;
        end
        ACT_CLEAR: begin
          count_nxt   = '0;
          pos_nxt     = '0;
          skipped_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (data_fire && !out_fire) inflight_nxt = inflight_r + CW'(1);
    else if (!data_fire && out_fire) inflight_nxt = inflight_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      inflight_r <= '0;
      pos_r      <= '0;
      skipped_r  <= '0;
    end else begin
      count_r    <= count_nxt;
      inflight_r <= inflight_nxt;
      pos_r      <= pos_nxt;
      skipped_r  <= skipped_nxt;
    end
  end

  always_comb begin
    head_item.pos      = pos_r;
    head_item.apply    = apply;
    head_item.data     = in_tdata[7:0];
    head_item.patched  = 1'b0;
    head_item.mismatch = 1'b0;
    head_item.last     = in_tlast;
  end

  assign chain_valid[0] = data_fire;
  assign chain_item[0]  = head_item;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ovbp_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .count     (count_r),
      .wr        (wr),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  assign out_tvalid = chain_valid[MAX_ENTRIES];
  assign out_tdata  = chain_item[MAX_ENTRIES].data;
  assign out_tuser  = {chain_item[MAX_ENTRIES].mismatch, chain_item[MAX_ENTRIES].patched};
  assign out_tlast  = chain_item[MAX_ENTRIES].last;

  a_table_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((act == ACT_APPEND) || (act == ACT_CLEAR)) |-> inflight_r == '0)
    else $error("table changed with words in the chain");

  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != '0)
    else $error("output word not counted in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CW'(MAX_ENTRIES))
    else $error("in-flight count above chain length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

endmodule
